>>> hdl/generational_slot_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
// Each macro expects clk and rst_n in scope.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// Condition must hold at every edge out of reset.
`define GSA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: lbl");

// Consequent must hold in the cycle after the antecedent.
`define GSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

>>> hdl/gsa_pkg.sv
package gsa_pkg;

    localparam int STALE_W = 32;
    localparam logic [STALE_W-1:0] STALE_MAX = {STALE_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_RESOLVE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STS_OK           = 2'd0,
        STS_EXHAUSTED    = 2'd1,
        STS_STALE        = 2'd2,
        STS_NOT_OCCUPIED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_READ = 3'b100
    } state_t;

endpackage

>>> hdl/generational_slot_allocator.sv
// Generational slot allocator: hands out (slot, generation) handles.
// Request channel s_*: s_tuser carries the action (allocate, release,
// resolve); s_tdata carries slot index and handle generation.
// Result channel m_*: one result per request, in order; m_tuser is the
// status, m_tdata the granted slot, its generation and both counters.
// Flow: an accepted request reads the table, then writes back; an
// allocate that pops the free stack reads the stack RAM first, since
// the popped slot must come back from it before the table can be read.
// Results show up in the output register the cycle after write-back.
// A request is taken while the previous result still waits; the next
// one then holds in its write-back cycle until the result register
// drains, so a stalled receiver stops the block after one request.
// Reset clears all counters. The generation/occupancy table needs no
// clearing pass: entries at or above the high-water mark were never
// written and read as zero, so the block is ready right out of reset.
`include "generational_slot_allocator_macros.svh"

module generational_slot_allocator #(
    parameter int SLOTS    = 256,
    parameter int GEN_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    // request
    input  logic s_tvalid,
    output logic s_tready,
    // slot, handle_generation (from bit 0 up), zero padded
    input  logic [((($clog2(SLOTS) + GEN_BITS) + 7) / 8) * 8 - 1:0] s_tdata,
    // action
    input  logic [1:0] s_tuser,
    // result
    output logic m_tvalid,
    input  logic m_tready,
    // granted_slot, slot_generation, live_count, stale_count, zero padded
    output logic [((($clog2(SLOTS) + GEN_BITS + $clog2(SLOTS + 1) + 32) + 7) / 8) * 8 - 1:0]
                 m_tdata,
    // status
    output logic [1:0] m_tuser
);

    import gsa_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int OUT_W  = (((IDX_W + GEN_BITS + CNT_W + STALE_W) + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    // request decode
    logic                accept;
    action_t             in_act;
    logic [IDX_W-1:0]    in_idx;
    logic [GEN_BITS-1:0] in_hgen;
    logic                in_range_in;

    // request context
    state_t              state_reg, state_next;
    action_t             act_reg, act_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [GEN_BITS-1:0] hgen_reg, hgen_next;
    logic                in_range_reg, in_range_next;
    logic                exhaust_reg, exhaust_next;
    logic                popped_reg, popped_next;

    // counters
    logic [CNT_W-1:0]    free_depth_reg, free_depth_next;
    logic [CNT_W-1:0]    high_water_reg, high_water_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [STALE_W-1:0]  stale_reg, stale_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [IDX_W-1:0]    out_slot_reg, out_slot_next;
    logic [GEN_BITS-1:0] out_gen_reg, out_gen_next;
    logic [CNT_W-1:0]    out_live_reg, out_live_next;
    logic [STALE_W-1:0]  out_stale_reg, out_stale_next;

    // table RAM: {occupied, generation}
    logic                tab_we, tab_re;
    logic [IDX_W-1:0]    tab_raddr;
    logic [GEN_BITS:0]   tab_wdata, tab_rdata;
    // free stack RAM
    logic                stk_we, stk_re;
    logic [IDX_W-1:0]    stk_raddr, stk_rdata;

    // current slot state as seen at write-back
    logic                known;
    logic                occ_cur;
    logic [GEN_BITS-1:0] gen_cur, gen_alloc, gen_inc, gen_rel;
    logic [CNT_W-1:0]    depth_m1;

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid & s_tready;
    assign in_act      = action_t'(s_tuser);
    assign in_idx      = s_tdata[IDX_W-1:0];
    assign in_hgen     = s_tdata[IDX_W +: GEN_BITS];
    assign in_range_in = CNT_W'(in_idx) < SLOTS_C;
    assign depth_m1    = free_depth_reg - CNT_W'(1);

    // never-written entries lie at or above high water and read as zero
    assign known     = in_range_reg && (CNT_W'(slot_reg) < high_water_reg);
    assign occ_cur   = known & tab_rdata[GEN_BITS];
    assign gen_cur   = known ? tab_rdata[GEN_BITS-1:0] : '0;
    assign gen_alloc = (gen_cur == '0) ? GEN_BITS'(1) : gen_cur;
    assign gen_inc   = gen_cur + GEN_BITS'(1);
    assign gen_rel   = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

    gsa_ram #(
        .WIDTH (GEN_BITS + 1),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (slot_reg),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    gsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (free_depth_reg[IDX_W-1:0]),
        .wdata (slot_reg),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        slot_next       = slot_reg;
        hgen_next       = hgen_reg;
        in_range_next   = in_range_reg;
        exhaust_next    = exhaust_reg;
        popped_next     = popped_reg;
        free_depth_next = free_depth_reg;
        high_water_next = high_water_reg;
        live_next       = live_reg;
        stale_next      = stale_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_gen_next    = out_gen_reg;
        out_live_next   = out_live_reg;
        out_stale_next  = out_stale_reg;
        tab_re          = 1'b0;
        tab_raddr       = slot_reg;
        tab_we          = 1'b0;
        tab_wdata       = {1'b0, gen_cur};
        stk_re          = 1'b0;
        stk_raddr       = depth_m1[IDX_W-1:0];
        stk_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next      = in_act;
                    hgen_next     = in_hgen;
                    in_range_next = in_range_in;
                    exhaust_next  = 1'b0;
                    popped_next   = 1'b0;
                    slot_next     = in_idx;
                    state_next    = ST_READ;
                    if (in_act == ACT_ALLOC)
                    begin
                        in_range_next = 1'b1;
                        if (free_depth_reg != '0)
                        begin
                            // reuse the most recently released slot
                            stk_re      = 1'b1;
                            popped_next = 1'b1;
                            state_next  = ST_POP;
                        end
                        else
                        begin
                            slot_next    = high_water_reg[IDX_W-1:0];
                            exhaust_next = (high_water_reg == SLOTS_C);
                        end
                    end
                    tab_re    = (state_next == ST_READ);
                    tab_raddr = slot_next;
                end
            end

            ST_POP:
            begin
                slot_next  = stk_rdata;
                tab_re     = 1'b1;
                tab_raddr  = stk_rdata;
                state_next = ST_READ;
            end

            ST_READ:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STS_OK;
                    out_slot_next   = '0;
                    out_gen_next    = '0;
                    state_next      = ST_IDLE;
                    case (act_reg)
                        ACT_ALLOC:
                        begin
                            if (exhaust_reg)
                            begin
                                out_status_next = STS_EXHAUSTED;
                            end
                            else
                            begin
                                tab_we        = 1'b1;
                                tab_wdata     = {1'b1, gen_alloc};
                                live_next     = live_reg + CNT_W'(1);
                                out_slot_next = slot_reg;
                                out_gen_next  = gen_alloc;
                                if (popped_reg)
                                begin
                                    free_depth_next = depth_m1;
                                end
                                else
                                begin
                                    high_water_next = high_water_reg + CNT_W'(1);
                                end
                            end
                        end

                        ACT_RELEASE:
                        begin
                            if (!occ_cur)
                            begin
                                out_status_next = STS_NOT_OCCUPIED;
                                out_gen_next    = gen_cur;
                            end
                            else
                            begin
                                tab_we          = 1'b1;
                                tab_wdata       = {1'b0, gen_rel};
                                stk_we          = 1'b1;
                                free_depth_next = free_depth_reg + CNT_W'(1);
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - CNT_W'(1);
                                end
                                out_slot_next = slot_reg;
                                out_gen_next  = gen_rel;
                            end
                        end

                        ACT_RESOLVE:
                        begin
                            if (hgen_reg == '0)
                            begin
                                out_status_next = STS_STALE;
                            end
                            else if (!occ_cur)
                            begin
                                out_status_next = STS_NOT_OCCUPIED;
                            end
                            else if (gen_cur != hgen_reg)
                            begin
                                out_status_next = STS_STALE;
                            end
                            out_gen_next = gen_cur;
                            if (out_status_next == STS_OK)
                            begin
                                out_slot_next = slot_reg;
                            end
                            else if (stale_reg != STALE_MAX)
                            begin
                                stale_next = stale_reg + STALE_W'(1);
                            end
                        end

                        default:
                        begin
                            // unused action code: plain ok result, no change
                            out_status_next = STS_OK;
                        end
                    endcase
                    out_live_next  = live_next;
                    out_stale_next = stale_next;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_depth_reg <= '0;
            high_water_reg <= '0;
            live_reg       <= '0;
            stale_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_depth_reg <= free_depth_next;
            high_water_reg <= high_water_next;
            live_reg       <= live_next;
            stale_reg      <= stale_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        slot_reg       <= slot_next;
        hgen_reg       <= hgen_next;
        in_range_reg   <= in_range_next;
        exhaust_reg    <= exhaust_next;
        popped_reg     <= popped_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_gen_reg    <= out_gen_next;
        out_live_reg   <= out_live_next;
        out_stale_reg  <= out_stale_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_W'({out_stale_reg, out_live_reg, out_gen_reg, out_slot_reg});

    // every slot below high water is either live or on the free stack
    `GSA_ASSERT_ALWAYS(a_slot_balance,
        (({1'b0, free_depth_reg} + {1'b0, live_reg}) == {1'b0, high_water_reg}))
    `GSA_ASSERT_ALWAYS(a_high_water_bound, high_water_reg <= SLOTS_C)
    `GSA_ASSERT_NEXT(a_stale_monotonic, 1'b1, stale_reg >= $past(stale_reg))

endmodule

>>> hdl/gsa_ram.sv
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import gsa_pkg::*;

    // Layout of the buses at the default SLOTS = 256, GEN_BITS = 16.
    localparam int SLOT_W    = 8;
    localparam int GEN_W     = 16;
    localparam int LIVE_W    = 9;
    localparam int NUM_SLOTS = 256;
    localparam int S_DATA_W  = 24;   // 8 + 16, already whole bytes
    localparam int M_DATA_W  = 72;   // 8 + 16 + 9 + 32 = 65, padded to 72

    // Action code 3 has no meaning in the block; it must come back as a no-op.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 100_000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;    // slot [7:0], handle_generation [23:8]
    logic [1:0]          s_tuser;    // action
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;    // granted_slot [7:0], slot_generation [23:8],
                                     // live_count [32:24], stale_count [64:33]
    logic [1:0]          m_tuser;    // status

    generational_slot_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    typedef struct {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [GEN_W-1:0]     gen;
        logic [LIVE_W-1:0]    live;
        logic [STALE_W-1:0]   stale;
    } alloc_result_t;

    // Shadow copy of the allocator state, advanced once per accepted request.
    logic [GEN_W-1:0]   shadow_gen [NUM_SLOTS];
    bit                 shadow_busy [NUM_SLOTS];
    logic [SLOT_W-1:0]  shadow_free [NUM_SLOTS];   // LIFO of released slots
    int                 shadow_free_top;
    int                 shadow_fresh;              // next never-used slot
    int                 shadow_live;
    logic [STALE_W-1:0] shadow_stale;
    logic [SLOT_W-1:0]  last_grant;

    alloc_result_t pending_results [$];

    int idle_pct;    // chance (percent) that the sender skips a cycle
    int stall_pct;   // chance (percent) that the receiver holds off
    int mismatches;
    int cycle_count;

    // ------------------------------------------------------------------
    // Clock, hard stop, and the receiver's random backpressure
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Hard stop in case the block hangs or results go missing.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Expected outcome of one request; updates the shadow state
    // ------------------------------------------------------------------
    function automatic alloc_result_t allocator_outcome(input logic [1:0] act,
                                                        input logic [SLOT_W-1:0] idx,
                                                        input logic [GEN_W-1:0] hgen);
        alloc_result_t r;
        logic [SLOT_W-1:0] s;
        logic [GEN_W-1:0] g;
        r.status = STS_OK;
        r.slot   = '0;
        r.gen    = '0;
        case (act)
            ACT_ALLOC:
            begin
                if (shadow_free_top == 0 && shadow_fresh >= NUM_SLOTS)
                begin
                    r.status = STS_EXHAUSTED;   // nothing changes
                end
                else
                begin
                    if (shadow_free_top > 0)
                    begin
                        shadow_free_top--;
                        s = shadow_free[shadow_free_top];
                    end
                    else
                    begin
                        s = shadow_fresh[SLOT_W-1:0];
                        shadow_fresh++;
                    end
                    shadow_busy[s] = 1'b1;
                    if (shadow_gen[s] == '0)
                        shadow_gen[s] = GEN_W'(1);
                    shadow_live++;
                    last_grant = s;
                    r.slot = s;
                    r.gen  = shadow_gen[s];
                end
            end
            ACT_RELEASE:
            begin
                if (!shadow_busy[idx])
                begin
                    r.status = STS_NOT_OCCUPIED;
                    r.gen    = shadow_gen[idx];
                end
                else
                begin
                    shadow_busy[idx] = 1'b0;
                    g = shadow_gen[idx] + 1'b1;
                    if (g == '0)
                        g = GEN_W'(1);  // generation 0 is reserved for "invalid"
                    shadow_gen[idx] = g;
                    shadow_free[shadow_free_top] = idx;
                    shadow_free_top++;
                    if (shadow_live > 0)
                        shadow_live--;
                    r.slot = idx;
                    r.gen  = g;
                end
            end
            ACT_RESOLVE:
            begin
                if (hgen == '0)
                    r.status = STS_STALE;
                else if (!shadow_busy[idx])
                    r.status = STS_NOT_OCCUPIED;
                else if (shadow_gen[idx] != hgen)
                    r.status = STS_STALE;
                r.gen = shadow_gen[idx];
                if (r.status == STS_OK)
                    r.slot = idx;
                else if (shadow_stale != STALE_MAX)
                    shadow_stale++;
            end
            default: ;                  // unused code: ok, zero slot and generation
        endcase
        r.live  = shadow_live[LIVE_W-1:0];
        r.stale = shadow_stale;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Tasks are entered and left on a falling edge; tvalid
    // stays high on exit so back-to-back requests need no gap.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] act,
                                input logic [SLOT_W-1:0] idx,
                                input logic [GEN_W-1:0] hgen);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {hgen, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), allocator_outcome(act, idx, hgen));
        @(negedge clk);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [SLOT_W-1:0] pick_live_slot();
        logic [SLOT_W-1:0] live_slots [$];
        for (int i = 0; i < NUM_SLOTS; i++)
            if (shadow_busy[i])
                live_slots.insert(live_slots.size(), i[SLOT_W-1:0]);
        return live_slots[$urandom_range(live_slots.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [STALE_W-1:0] want,
                                 input logic [STALE_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $error("result with no request outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", want.status, m_tuser);
                compare_field("granted_slot", want.slot, m_tdata[7:0]);
                compare_field("slot_generation", want.gen, m_tdata[23:8]);
                compare_field("live_count", want.live, m_tdata[32:24]);
                compare_field("stale_count", want.stale, m_tdata[64:33]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked corners on a fresh block.
    task automatic test_directed();
        send_request(ACT_RESOLVE, 8'd0, 16'd0);       // generation 0 is never valid
        send_request(ACT_RESOLVE, 8'd255, 16'hFFFF);  // slot never allocated
        send_request(ACT_RELEASE, 8'd0, 16'd0);       // release of a free slot
        send_request(ACT_ALLOC, 8'd0, 16'd0);         // fresh slot 0, gen 0 -> 1
        send_request(ACT_ALLOC, 8'hFF, 16'hFFFF);     // fresh slot 1, fields ignored
        send_request(ACT_RESOLVE, 8'd0, 16'd1);       // good handle
        send_request(ACT_RESOLVE, 8'd0, 16'd2);       // generation mismatch
        send_request(ACT_RESOLVE, 8'd0, 16'd0);       // live slot, invalid generation
        send_request(ACT_RELEASE, 8'd0, 16'd0);       // slot 0 -> gen 2
        send_request(ACT_RELEASE, 8'd0, 16'd0);       // double release
        send_request(ACT_RESOLVE, 8'd0, 16'd1);       // handle to a freed slot
        send_request(ACT_ALLOC, 8'd0, 16'd0);         // reuses slot 0 at gen 2
        send_request(ACT_RELEASE, 8'd1, 16'd0);
        send_request(ACT_RELEASE, 8'd0, 16'd0);
        send_request(ACT_ALLOC, 8'd0, 16'd0);         // LIFO: slot 0 first
        send_request(ACT_ALLOC, 8'd0, 16'd0);         // then slot 1
        send_request(ACT_ALLOC, 8'd0, 16'd0);         // stack empty: fresh slot 2
        send_request(ACT_UNUSED, 8'hA5, 16'h5A5A);    // no-op action
        send_request(ACT_RESOLVE, 8'd2, 16'h8000);    // high bit, wrong generation
        send_request(ACT_RESOLVE, 8'd1, 16'd2);
        send_request(ACT_RESOLVE, 8'd0, 16'd3);
        drain_results();
    endtask

    // Mostly well-formed traffic on live handles, with stale and junk mixed in.
    task automatic test_random_traffic(input int count);
        int pick;
        logic [SLOT_W-1:0] s;
        for (int i = 0; i < count; i++)
        begin
            // a long stretch with both sides running flat out
            if (i == count / 3)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            if (i == 2 * count / 3)
            begin
                idle_pct  = 9;
                stall_pct = 9;
            end
            pick = $urandom_range(99);
            if (shadow_live == 0 || pick < 35)
                send_request(ACT_ALLOC, SLOT_W'($urandom_range(255)),
                             GEN_W'($urandom_range(16'hFFFF)));
            else if (pick < 65)
            begin
                s = ($urandom_range(99) < 85) ? pick_live_slot()
                                              : SLOT_W'($urandom_range(255));
                send_request(ACT_RELEASE, s, GEN_W'($urandom_range(16'hFFFF)));
            end
            else if (pick < 95)
            begin
                pick = $urandom_range(99);
                s = pick_live_slot();
                if (pick < 70)
                    send_request(ACT_RESOLVE, s, shadow_gen[s]);
                else if (pick < 80)
                    send_request(ACT_RESOLVE, s, shadow_gen[s] - 1'b1);
                else if (pick < 85)
                    send_request(ACT_RESOLVE, s, 16'd0);
                else
                    send_request(ACT_RESOLVE, SLOT_W'($urandom_range(255)),
                                 GEN_W'($urandom_range(16'hFFFF)));
            end
            else
                send_request(ACT_UNUSED, SLOT_W'($urandom_range(255)),
                             GEN_W'($urandom_range(16'hFFFF)));
        end
        drain_results();
    endtask

    // Fill every slot, hit the capacity limit, then free everything.
    task automatic test_exhaustion();
        logic [SLOT_W-1:0] order [NUM_SLOTS];
        logic [SLOT_W-1:0] tmp;
        int j;
        while (shadow_live < NUM_SLOTS)
            send_request(ACT_ALLOC, 8'd0, 16'd0);
        send_request(ACT_ALLOC, 8'd0, 16'd0);
        send_request(ACT_ALLOC, 8'hFF, 16'hFFFF);
        send_request(ACT_RESOLVE, 8'd255, shadow_gen[255]);
        for (int i = 0; i < NUM_SLOTS; i++)
            order[i] = i[SLOT_W-1:0];
        for (int i = NUM_SLOTS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i])
            send_request(ACT_RELEASE, order[i], 16'd0);
        send_request(ACT_RELEASE, order[0], 16'd0);   // already free
        send_request(ACT_ALLOC, 8'd0, 16'd0);          // pops last released
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_ALLOC;
        idle_pct  = 9;
        stall_pct = 9;
        mismatches = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_gen[i]  = '0;
            shadow_busy[i] = 1'b0;
            shadow_free[i] = '0;
        end
        shadow_free_top = 0;
        shadow_fresh    = 0;
        shadow_live     = 0;
        shadow_stale    = '0;
        last_grant      = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_traffic(500);
        test_exhaustion();

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> generational_slot_allocator.f
+incdir+hdl
hdl/gsa_pkg.sv
hdl/gsa_ram.sv
hdl/generational_slot_allocator.sv
tb/sv/testbench.sv
